FILE: rtl/core/tcmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmp_pkg
// Shared constants, codes and saturating helpers for the two-compartment
// tissue Euler step block.
// ----------------------------------------------------------------------------
package tcmp_pkg;

  // Fixed-point format and counter width.
  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 16;

  // Field widths.
  localparam int RATE_W  = 20;
  localparam int WIN_W   = 32;
  localparam int FRACT_W = 17;
  localparam int CP_W    = 31;
  localparam int DT_W    = 18;
  localparam int CONC_W  = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_UPTAKE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EFFLUX      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BIND_BASE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BIND_FIRST  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BIND_SECOND = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_FIRST   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_SECOND  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PLASMA_FR   = 3'd7;

  // Digit-serial multiplier: signed multiplicand, unsigned multiplier
  // consumed one digit a cycle, least significant digit first.
  localparam int DIGIT_W   = 4;
  localparam int MUL_A_W   = CONC_W + 1;
  localparam int MUL_B_W   = 24;
  localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
  localparam int STEP_W    = 3;
  localparam int PP_W      = MUL_A_W + DIGIT_W + 1;
  localparam int HI_W      = PP_W - DIGIT_W;
  localparam int PROD_W    = HI_W + MUL_B_W;
  localparam int SHR_W     = PROD_W - FRAC_BITS;

  // Product sequence of one item.
  typedef enum logic [2:0] {
    OP_GAIN   = 3'd0,
    OP_LOSS   = 3'd1,
    OP_BIND   = 3'd2,
    OP_FREE_D = 3'd3,
    OP_BND_D  = 3'd4,
    OP_PLASMA = 3'd5
  } op_t;

  function automatic logic signed [CONC_W-1:0] sat_add(
    input logic signed [CONC_W-1:0] a,
    input logic signed [CONC_W-1:0] b
  );
    logic signed [CONC_W:0] s;
    s = {a[CONC_W-1], a} + {b[CONC_W-1], b};
    if (s[CONC_W] != s[CONC_W-1]) begin
      sat_add = s[CONC_W] ? {1'b1, {(CONC_W-1){1'b0}}} : {1'b0, {(CONC_W-1){1'b1}}};
    end else begin
      sat_add = s[CONC_W-1:0];
    end
  endfunction

  function automatic logic signed [CONC_W-1:0] sat_sub(
    input logic signed [CONC_W-1:0] a,
    input logic signed [CONC_W-1:0] b
  );
    logic signed [CONC_W:0] s;
    s = {a[CONC_W-1], a} - {b[CONC_W-1], b};
    if (s[CONC_W] != s[CONC_W-1]) begin
      sat_sub = s[CONC_W] ? {1'b1, {(CONC_W-1){1'b0}}} : {1'b0, {(CONC_W-1){1'b1}}};
    end else begin
      sat_sub = s[CONC_W-1:0];
    end
  endfunction

  // Saturate the already shifted product to the concentration width.
  function automatic logic signed [CONC_W-1:0] sat_shr(input logic signed [SHR_W-1:0] v);
    if (v > SHR_W'(signed'({1'b0, {(CONC_W-1){1'b1}}}))) begin
      sat_shr = {1'b0, {(CONC_W-1){1'b1}}};
    end else if (v < -SHR_W'(signed'({1'b0, 1'b1, {(CONC_W-1){1'b0}}}))) begin
      sat_shr = {1'b1, {(CONC_W-1){1'b0}}};
    end else begin
      sat_shr = v[CONC_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/tissue_compartment_euler_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tissue_compartment_euler_step_top
// Two-compartment tissue model: one forward Euler step of the free and bound
// concentrations per plasma sample, Q16.16 with saturation, digit-serial.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | slave     | tdata: plasma_conc[30:0], step_size[48:31]; tuser: restart
//  out_    | master    | tdata: free_out[31:0], bound_out[63:32], total_out[95:64]
//  cfg_    | write     | cfg_addr selects one of eight registers, cfg_wdata value
//
// An item that advances the concentrations runs six products; the first sample
// of a run needs only the plasma product. The products share one multiplier
// that consumes a 4-bit digit of its operand each cycle, after a load step for
// each product. A finished result waits in the output register while the next
// item is accepted and worked on.
// Reset clears the configuration registers, concentrations and the sample counter.
// ----------------------------------------------------------------------------
module tissue_compartment_euler_step_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // plasma_conc [30:0], step_size [48:31], zero fill
  input  logic         in_tuser,   // restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // free_out [31:0], bound_out [63:32], total_out [95:64]
  input  logic         cfg_we,
  input  logic [tcmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tcmp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_UPD,
    ST_SUM,
    ST_FIN
  } state_t;

  localparam int CW = tcmp_pkg::CONC_W;
  localparam int IW = tcmp_pkg::INDEX_BITS;

  // Configuration registers.
  logic [tcmp_pkg::RATE_W-1:0]  uptake_r, efflux_r, k3_base_r, k3_first_r, k3_second_r;
  logic [tcmp_pkg::WIN_W-1:0]   win_first_r, win_second_r;
  logic [tcmp_pkg::FRACT_W-1:0] plasma_fr_r;

  // Sequencer and state.
  state_t                       state_r, state_nxt;
  tcmp_pkg::op_t                op_r, op_nxt;
  logic [tcmp_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic signed [CW-1:0]         free_r, free_nxt, bound_r, bound_nxt;
  logic [IW-1:0]                count_r, count_nxt;
  logic                         active_r, active_nxt;
  logic [tcmp_pkg::CP_W-1:0]    cp_r, cp_nxt;
  logic [tcmp_pkg::DT_W-1:0]    dt_r, dt_nxt;
  logic [tcmp_pkg::RATE_W-1:0]  k3_r, k3_nxt;

  // Product results.
  logic signed [CW-1:0] gain_r, gain_nxt, loss_r, loss_nxt, dcb_r, dcb_nxt;
  logic signed [CW-1:0] t_free_r, t_free_nxt, t_bnd_r, t_bnd_nxt;
  logic signed [CW-1:0] plasma_r, plasma_nxt, sum_r, sum_nxt;

  // Multiplier datapath.
  logic signed [tcmp_pkg::MUL_A_W-1:0] mul_a_r, mul_a_nxt;
  logic [tcmp_pkg::MUL_B_W-1:0]        mul_b_r, mul_b_nxt;
  logic signed [tcmp_pkg::HI_W-1:0]    hi_r, hi_nxt;
  logic [tcmp_pkg::MUL_B_W-1:0]        lo_r, lo_nxt;
  logic signed [tcmp_pkg::PP_W-1:0]    pp_sum;
  logic signed [tcmp_pkg::PROD_W-1:0]  prod;
  logic signed [CW-1:0]                mul_res;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [95:0]   out_data_r, out_data_nxt;

  // Accept-time decode.
  logic          in_acc;
  logic [IW-1:0] n_cur;
  logic          in_w1, in_w2;
  logic [tcmp_pkg::RATE_W:0] k23_sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_acc     = in_tvalid && in_tready;

  assign n_cur = in_tuser ? '0 : count_r;
  assign in_w1 = (n_cur > win_first_r[IW-1:0]) && (n_cur < win_first_r[2*IW-1:IW]);
  assign in_w2 = (n_cur > win_second_r[IW-1:0]) && (n_cur < win_second_r[2*IW-1:IW]);
  assign k23_sum = {1'b0, efflux_r} + {1'b0, k3_r};

  // One digit step: add the partial product to the high half, then shift the
  // low digit out into the low half. Arithmetic shift keeps the floor rounding.
  assign pp_sum = $signed({{(tcmp_pkg::PP_W-tcmp_pkg::HI_W){hi_r[tcmp_pkg::HI_W-1]}}, hi_r})
                + mul_a_r * $signed({1'b0, mul_b_r[tcmp_pkg::DIGIT_W-1:0]});
  assign prod    = {pp_sum[tcmp_pkg::PP_W-1:tcmp_pkg::DIGIT_W],
                    pp_sum[tcmp_pkg::DIGIT_W-1:0],
                    lo_r[tcmp_pkg::MUL_B_W-1:tcmp_pkg::DIGIT_W]};
  assign mul_res = tcmp_pkg::sat_shr(prod[tcmp_pkg::PROD_W-1:tcmp_pkg::FRAC_BITS]);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    free_nxt      = free_r;
    bound_nxt     = bound_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    cp_nxt        = cp_r;
    dt_nxt        = dt_r;
    k3_nxt        = k3_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    dcb_nxt       = dcb_r;
    t_free_nxt    = t_free_r;
    t_bnd_nxt     = t_bnd_r;
    plasma_nxt    = plasma_r;
    sum_nxt       = sum_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cp_nxt     = in_tdata[tcmp_pkg::CP_W-1:0];
          dt_nxt     = in_tdata[tcmp_pkg::CP_W +: tcmp_pkg::DT_W];
          active_nxt = (n_cur != '0);
          if (in_w1) begin
            k3_nxt = k3_first_r;
          end else if (in_w2) begin
            k3_nxt = k3_second_r;
          end else begin
            k3_nxt = k3_base_r;
          end
          if (in_tuser) begin
            free_nxt  = '0;
            bound_nxt = '0;
          end
          count_nxt = (n_cur == '1) ? n_cur : n_cur + 1'b1;
          op_nxt    = (n_cur != '0) ? tcmp_pkg::OP_GAIN : tcmp_pkg::OP_PLASMA;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        hi_nxt   = '0;
        lo_nxt   = '0;
        step_nxt = '0;
        case (op_r)
          tcmp_pkg::OP_GAIN: begin
            mul_a_nxt = $signed({2'b00, cp_r});
            mul_b_nxt = tcmp_pkg::MUL_B_W'(uptake_r);
          end
          tcmp_pkg::OP_LOSS: begin
            mul_a_nxt = {free_r[CW-1], free_r};
            mul_b_nxt = tcmp_pkg::MUL_B_W'(k23_sum);
          end
          tcmp_pkg::OP_BIND: begin
            mul_a_nxt = {free_r[CW-1], free_r};
            mul_b_nxt = tcmp_pkg::MUL_B_W'(k3_r);
          end
          tcmp_pkg::OP_FREE_D: begin
            mul_a_nxt = {1'b0, tcmp_pkg::sat_sub(gain_r, loss_r)};
            mul_a_nxt[CW] = mul_a_nxt[CW-1];
            mul_b_nxt = tcmp_pkg::MUL_B_W'(dt_r);
          end
          tcmp_pkg::OP_BND_D: begin
            mul_a_nxt = {dcb_r[CW-1], dcb_r};
            mul_b_nxt = tcmp_pkg::MUL_B_W'(dt_r);
          end
          default: begin
            mul_a_nxt = $signed({2'b00, cp_r});
            mul_b_nxt = tcmp_pkg::MUL_B_W'(plasma_fr_r);
          end
        endcase
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        hi_nxt    = pp_sum[tcmp_pkg::PP_W-1:tcmp_pkg::DIGIT_W];
        lo_nxt    = {pp_sum[tcmp_pkg::DIGIT_W-1:0],
                     lo_r[tcmp_pkg::MUL_B_W-1:tcmp_pkg::DIGIT_W]};
        mul_b_nxt = mul_b_r >> tcmp_pkg::DIGIT_W;
        step_nxt  = step_r + 1'b1;
        if (step_r == tcmp_pkg::STEP_W'(tcmp_pkg::MUL_STEPS - 1)) begin
          case (op_r)
            tcmp_pkg::OP_GAIN:   gain_nxt   = mul_res;
            tcmp_pkg::OP_LOSS:   loss_nxt   = mul_res;
            tcmp_pkg::OP_BIND:   dcb_nxt    = mul_res;
            tcmp_pkg::OP_FREE_D: t_free_nxt = mul_res;
            tcmp_pkg::OP_BND_D:  t_bnd_nxt  = mul_res;
            default:             plasma_nxt = mul_res;
          endcase
          if (op_r == tcmp_pkg::OP_PLASMA) begin
            state_nxt = ST_UPD;
          end else begin
            op_nxt    = tcmp_pkg::op_t'(op_r + 3'd1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_UPD: begin
        if (active_r) begin
          free_nxt  = tcmp_pkg::sat_add(free_r, t_free_r);
          bound_nxt = tcmp_pkg::sat_add(bound_r, t_bnd_r);
        end
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = tcmp_pkg::sat_add(free_r, bound_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tcmp_pkg::sat_add(sum_r, plasma_r), bound_r, free_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= tcmp_pkg::OP_GAIN;
      step_r       <= '0;
      free_r       <= '0;
      bound_r      <= '0;
      count_r      <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      uptake_r     <= '0;
      efflux_r     <= '0;
      k3_base_r    <= '0;
      k3_first_r   <= '0;
      k3_second_r  <= '0;
      win_first_r  <= '0;
      win_second_r <= '0;
      plasma_fr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      step_r      <= step_nxt;
      free_r      <= free_nxt;
      bound_r     <= bound_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          tcmp_pkg::REG_UPTAKE:      uptake_r     <= cfg_wdata[tcmp_pkg::RATE_W-1:0];
          tcmp_pkg::REG_EFFLUX:      efflux_r     <= cfg_wdata[tcmp_pkg::RATE_W-1:0];
          tcmp_pkg::REG_BIND_BASE:   k3_base_r    <= cfg_wdata[tcmp_pkg::RATE_W-1:0];
          tcmp_pkg::REG_BIND_FIRST:  k3_first_r   <= cfg_wdata[tcmp_pkg::RATE_W-1:0];
          tcmp_pkg::REG_BIND_SECOND: k3_second_r  <= cfg_wdata[tcmp_pkg::RATE_W-1:0];
          tcmp_pkg::REG_WIN_FIRST:   win_first_r  <= cfg_wdata[tcmp_pkg::WIN_W-1:0];
          tcmp_pkg::REG_WIN_SECOND:  win_second_r <= cfg_wdata[tcmp_pkg::WIN_W-1:0];
          tcmp_pkg::REG_PLASMA_FR:   plasma_fr_r  <= cfg_wdata[tcmp_pkg::FRACT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    cp_r       <= cp_nxt;
    dt_r       <= dt_nxt;
    k3_r       <= k3_nxt;
    gain_r     <= gain_nxt;
    loss_r     <= loss_nxt;
    dcb_r      <= dcb_nxt;
    t_free_r   <= t_free_nxt;
    t_bnd_r    <= t_bnd_nxt;
    plasma_r   <= plasma_nxt;
    sum_r      <= sum_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
  end

  // The digit counter never runs past the last digit of a product.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (step_r < tcmp_pkg::STEP_W'(tcmp_pkg::MUL_STEPS)))
    else $error("multiplier digit counter overran");

  // An accepted item keeps the input closed for at least the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item accepted while one is in progress");

  // A new result appears only from the final state of the sequence.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

  // The sample counter saturates instead of wrapping.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '1) && !(in_acc && in_tuser)) |=> (count_r == '1))
    else $error("sample counter wrapped");

endmodule

FILE: tb/tcmp_euler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmp_euler_checker
// Watches the sample, result and register write channels of the tissue
// compartment Euler step block. It keeps its own copy of the registers and the
// compartment state, works out the concentrations for each accepted sample,
// and compares every accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module tcmp_euler_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,   // plasma_conc [30:0], step_size [48:31], zero fill
  input  logic         in_tuser,   // restart
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,  // free_out [31:0], bound_out [63:32], total_out [95:64]
  input  logic         cfg_we,
  input  logic [tcmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tcmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int           fail_count,
  output int           pending
);
  import tcmp_pkg::*;

  typedef struct packed {
    logic signed [CONC_W-1:0] free_val;
    logic signed [CONC_W-1:0] bound_val;
    logic signed [CONC_W-1:0] total_val;
  } conc_set_t;

  conc_set_t expected_conc_q[$];
  conc_set_t want;

  logic [RATE_W-1:0]        uptake_r, efflux_r, bind_base_r, bind_first_r, bind_second_r;
  logic [WIN_W-1:0]         win_first_r, win_second_r;
  logic [FRACT_W-1:0]       plasma_fr_r;
  logic signed [CONC_W-1:0] free_c, bound_c;
  logic [INDEX_BITS-1:0]    sample_idx;
  int                       results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic logic signed [CONC_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Exact product, then an arithmetic shift, which floors towards minus infinity.
  function automatic logic signed [CONC_W-1:0] fixed_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic bit window_hit(input logic [WIN_W-1:0] w, input logic [INDEX_BITS-1:0] n);
    logic [INDEX_BITS-1:0] onset, offset;
    onset  = w[INDEX_BITS-1:0];
    offset = w[2*INDEX_BITS-1:INDEX_BITS];
    return (n > onset) && (n < offset);
  endfunction

  function automatic conc_set_t advance_compartments(input logic [CP_W-1:0] cp,
                                                     input logic [DT_W-1:0] dt,
                                                     input logic restart);
    longint                   k3, cf;
    logic signed [CONC_W-1:0] gain, loss, dcf, dcb, plasma, sum_fb;
    conc_set_t                r;
    if (restart) begin
      free_c     = '0;
      bound_c    = '0;
      sample_idx = '0;
    end
    // Window one takes priority where the two overlap.
    if (window_hit(win_first_r, sample_idx)) k3 = bind_first_r;
    else if (window_hit(win_second_r, sample_idx)) k3 = bind_second_r;
    else k3 = bind_base_r;
    // The first sample of a run only shows the held concentrations.
    if (sample_idx != '0) begin
      cf      = free_c;
      gain    = fixed_mul(uptake_r, cp);
      loss    = fixed_mul(longint'(efflux_r) + k3, cf);
      dcf     = clamp32(longint'(gain) - longint'(loss));
      dcb     = fixed_mul(k3, cf);
      free_c  = clamp32(cf + fixed_mul(dcf, dt));
      bound_c = clamp32(longint'(bound_c) + fixed_mul(dcb, dt));
    end
    if (sample_idx != '1) sample_idx = sample_idx + 1'b1;
    plasma      = fixed_mul(plasma_fr_r, cp);
    sum_fb      = clamp32(longint'(free_c) + longint'(bound_c));
    r.free_val  = free_c;
    r.bound_val = bound_c;
    r.total_val = clamp32(longint'(sum_fb) + longint'(plasma));
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    fail_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      uptake_r      = '0;
      efflux_r      = '0;
      bind_base_r   = '0;
      bind_first_r  = '0;
      bind_second_r = '0;
      win_first_r   = '0;
      win_second_r  = '0;
      plasma_fr_r   = '0;
      free_c        = '0;
      bound_c       = '0;
      sample_idx    = '0;
      expected_conc_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_UPTAKE:      uptake_r      = cfg_wdata[RATE_W-1:0];
          REG_EFFLUX:      efflux_r      = cfg_wdata[RATE_W-1:0];
          REG_BIND_BASE:   bind_base_r   = cfg_wdata[RATE_W-1:0];
          REG_BIND_FIRST:  bind_first_r  = cfg_wdata[RATE_W-1:0];
          REG_BIND_SECOND: bind_second_r = cfg_wdata[RATE_W-1:0];
          REG_WIN_FIRST:   win_first_r   = cfg_wdata[WIN_W-1:0];
          REG_WIN_SECOND:  win_second_r  = cfg_wdata[WIN_W-1:0];
          REG_PLASMA_FR:   plasma_fr_r   = cfg_wdata[FRACT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_conc_q.push_back(advance_compartments(in_tdata[CP_W-1:0],
                                                       in_tdata[CP_W+DT_W-1:CP_W],
                                                       in_tuser));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_conc_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_conc_q.pop_front();
          if (out_tdata[31:0] !== want.free_val)
            flag_mismatch($sformatf("result %0d free_out: expected %h, got %h",
                                    results_seen, want.free_val, out_tdata[31:0]));
          if (out_tdata[63:32] !== want.bound_val)
            flag_mismatch($sformatf("result %0d bound_out: expected %h, got %h",
                                    results_seen, want.bound_val, out_tdata[63:32]));
          if (out_tdata[95:64] !== want.total_val)
            flag_mismatch($sformatf("result %0d total_out: expected %h, got %h",
                                    results_seen, want.total_val, out_tdata[95:64]));
        end
      end
    end
    pending = expected_conc_q.size();
  end

endmodule

FILE: tb/tb_tissue_compartment_euler_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tissue_compartment_euler_step_top
// Drives plasma samples and register settings into the tissue compartment
// Euler step block with random gaps and result stalls: a short directed run
// over the extremes and the rate windows, then random runs of samples under
// several register settings. The checker beside the block judges the results.
// ----------------------------------------------------------------------------
module tb_tissue_compartment_euler_step_top;
  import tcmp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 52;
  localparam int PHASE_ITEMS  = 190;

  typedef enum int {SET_ZERO, SET_MAX, SET_OPEN_WINDOW, SET_RANDOM} setting_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [55:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [95:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  int unsigned           cycle_count = 0;
  bit                    tx_burst = 1'b0;
  bit                    rx_burst = 1'b0;

  tissue_compartment_euler_step_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tcmp_euler_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: a freshly drawn, possibly empty stall before every result, with stall-free stretches.
  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // All tasks below start and end just after a falling edge.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // The input is closed first so that no further item slips in while draining.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic feed_sample(input logic [CP_W-1:0] cp, input logic [DT_W-1:0] dt,
                             input logic restart);
    int gap;
    gap = tx_burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 56'({$urandom, $urandom});
      in_tuser  = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'b0, dt, cp};
    in_tuser  = restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CP_W-1:0] pick_plasma();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 6) return CP_W'($urandom);
    return CP_W'($urandom_range(0, 1 << 22));
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 6) return DT_W'($urandom);
    return DT_W'($urandom_range(0, 1 << 14));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    logic [CFG_DATA_W-1:0] v;
    v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, (1 << RATE_W) - 1)
                                    : $urandom_range(0, 1 << 17);
    // Bits above the register width must be dropped by the block.
    if ($urandom_range(0, 1) == 0) v = v | ($urandom << RATE_W);
    return v;
  endfunction

  task automatic apply_setting(input setting_kind_t kind);
    logic [CFG_DATA_W-1:0] vals [8];
    int                    i;
    settle();
    case (kind)
      SET_ZERO: begin
        for (i = 0; i < 8; i++) vals[i] = '0;
      end
      SET_MAX: begin
        vals[REG_UPTAKE]      = (1 << RATE_W) - 1;
        vals[REG_EFFLUX]      = (1 << RATE_W) - 1;
        vals[REG_BIND_BASE]   = (1 << RATE_W) - 1;
        vals[REG_BIND_FIRST]  = (1 << RATE_W) - 1;
        vals[REG_BIND_SECOND] = (1 << RATE_W) - 1;
        vals[REG_WIN_FIRST]   = '1;
        vals[REG_WIN_SECOND]  = '1;
        vals[REG_PLASMA_FR]   = 32'd65536;
      end
      SET_OPEN_WINDOW: begin
        vals[REG_UPTAKE]      = pick_rate();
        vals[REG_EFFLUX]      = pick_rate();
        vals[REG_BIND_BASE]   = pick_rate();
        vals[REG_BIND_FIRST]  = pick_rate();
        vals[REG_BIND_SECOND] = pick_rate();
        vals[REG_WIN_FIRST]   = {16'hFFFF, 16'h0000};
        vals[REG_WIN_SECOND]  = {16'd30, 16'd0};
        vals[REG_PLASMA_FR]   = $urandom_range(0, 65536);
      end
      default: begin
        vals[REG_UPTAKE]      = pick_rate();
        vals[REG_EFFLUX]      = pick_rate();
        vals[REG_BIND_BASE]   = pick_rate();
        vals[REG_BIND_FIRST]  = pick_rate();
        vals[REG_BIND_SECOND] = pick_rate();
        // Small sample indices so runs pass through the windows; some are empty.
        vals[REG_WIN_FIRST]   = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 20))};
        vals[REG_WIN_SECOND]  = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 20))};
        vals[REG_PLASMA_FR]   = $urandom_range(0, 65536) | ($urandom << FRACT_W);
      end
    endcase
    for (i = 0; i < 8; i++) write_reg(CFG_ADDR_W'(i), vals[i]);
  endtask

  initial begin
    setting_kind_t kind;
    int            phase, phase_items, run_len, k;
    bit            fresh_run;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: window one over samples 3 and 4, window two over 4 to 8.
    write_reg(REG_UPTAKE,      32'h0001_0000);
    write_reg(REG_EFFLUX,      32'h0000_8000);
    write_reg(REG_BIND_BASE,   32'h0000_4000);
    write_reg(REG_BIND_FIRST,  32'h0002_0000);
    write_reg(REG_BIND_SECOND, 32'h0000_1000);
    write_reg(REG_WIN_FIRST,   {16'd5, 16'd2});
    write_reg(REG_WIN_SECOND,  {16'd9, 16'd3});
    write_reg(REG_PLASMA_FR,   32'h0000_0CCC);
    feed_sample('1, '1, 1'b1);
    feed_sample('0, '0, 1'b0);
    feed_sample('1, '1, 1'b0);
    feed_sample(CP_W'(1 << 20), DT_W'(16'h4000), 1'b0);
    feed_sample('0, '1, 1'b0);
    for (k = 0; k < 6; k++) feed_sample(CP_W'(1 << 20), DT_W'(16'h4000), 1'b0);
    feed_sample(CP_W'(32'h0001_0000), DT_W'(16'h1000), 1'b1);
    feed_sample('1, '1, 1'b0);
    feed_sample('1, '1, 1'b0);
    feed_sample('0, '1, 1'b0);
    feed_sample('0, '1, 1'b0);

    // Random runs of samples, each phase under its own register setting.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       kind = SET_ZERO;
        1:       kind = SET_MAX;
        2:       kind = SET_OPEN_WINDOW;
        default: kind = SET_RANDOM;
      endcase
      apply_setting(kind);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        run_len  = $urandom_range(1, 45);
        tx_burst = ($urandom_range(0, 3) == 0);
        // Now and then a run carries on from the previous one without a restart.
        fresh_run = ($urandom_range(0, 5) != 0);
        for (k = 0; k < run_len; k++) begin
          feed_sample(pick_plasma(), pick_step(), (k == 0) && fresh_run);
          phase_items++;
        end
      end
    end

    in_tvalid = 1'b0;
    tx_burst  = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: tissue_compartment_euler_step_top.f
rtl/core/tcmp_pkg.sv
rtl/core/tissue_compartment_euler_step_top.sv
tb/tcmp_euler_checker.sv
tb/tb_tissue_compartment_euler_step_top.sv
